// File: rtl/assert_macros.svh
// Assertion macros used by the RTL of the scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant does not hold");

// Checks that a consequent holds in the cycle after an antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle consequence does not hold");

`endif

// File: rtl/arrs_pkg.sv
// Package with the constants and types of the round robin scanner.
`timescale 1ns / 1ps

package arrs_pkg;

    localparam int CHANNEL_COUNT = 7;
    localparam int SLOT_MAX      = 7;
    localparam int SLOT_W        = $clog2(SLOT_MAX + 1);

    localparam int SAMPLE_W  = 10;
    localparam int MUX_W     = 6;
    localparam int VALUE8_W  = 8;
    localparam int AVG_W     = 18;
    localparam int FRAC_W    = 8;
    localparam int KEEP_W    = 8;
    localparam int MAP_W     = SLOT_MAX * MUX_W;
    localparam int CFG_IDX_W = 2;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    localparam logic [MAP_W-1:0]  MAP_RESET  = 42'd2412799868992;
    localparam logic [KEEP_W-1:0] KEEP_RESET = 8'd230;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_MAP   = 2'd0,
        CFG_FILTER_ENABLE = 2'd1,
        CFG_FILTER_KEEP   = 2'd2
    } cfg_index_t;

    typedef enum logic {
        CMD_CONVERT = 1'b0,
        CMD_READ    = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [SAMPLE_W-1:0] sample;
        logic [SLOT_W-1:0]   read_slot;
    } in_item_t;

    typedef struct packed {
        logic                was_fresh;
        logic [VALUE8_W-1:0] read_value8;
        logic [SAMPLE_W-1:0] read_value;
        logic [SLOT_W-1:0]   scan_slot;
        logic [MUX_W-1:0]    next_mux;
    } out_item_t;

endpackage

// File: rtl/adc_round_robin_scanner.sv
// Round robin ADC scan sequencer with per-slot result registers and averaging.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The block takes one item per clock cycle while the output side keeps up
// and returns exactly one result item for each: an accepted item is held in
// the input register, and the single update pass behind it writes the slot
// stores and the result register together once the result register is free
// or emptying. That pass holds one 18 by 8 and one 18 by 9 bit multiply for
// the exponential average. A conversion item stores its sample in the
// current slot and the result reports the mux code and index of the slot
// that follows; a read item of a valid slot returns the slot's raw or averaged
// value and clears its fresh flag. Configuration writes take effect at the
// next clock edge.
module adc_round_robin_scanner
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: sample [9:0], read_slot [12:10], zero fill [15:13]
    input  logic [arrs_pkg::IN_DATA_W-1:0]   s_tdata,
    // s_tuser: cmd [0]
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: next_mux [5:0], scan_slot [8:6], read_value [18:9],
    // read_value8 [26:19], was_fresh [27], zero fill [31:28]
    output logic [arrs_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                             cfg_we,
    input  logic [arrs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [arrs_pkg::MAP_W-1:0]       cfg_data
);

    import arrs_pkg::*;

    logic [MAP_W-1:0]       map_reg;
    logic                   filt_en_reg;
    logic [KEEP_W-1:0]      keep_reg;

    logic                   in_valid_reg;
    in_item_t               in_reg;
    logic                   out_valid_reg;
    out_item_t              out_reg;
    out_item_t              out_next;

    logic [SLOT_W-1:0]      slot_reg;
    logic [SLOT_W-1:0]      slot_next;
    logic [SAMPLE_W-1:0]    raw_reg [CHANNEL_COUNT];
    logic [AVG_W-1:0]       avg_reg [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] fresh_reg;
    logic [CHANNEL_COUNT-1:0] seeded_reg;

    logic                   advance;
    logic                   is_conv;
    logic                   rd_ok;
    logic [SLOT_W-1:0]      addr;
    logic [SAMPLE_W-1:0]    raw_rd;
    logic [AVG_W-1:0]       avg_rd;
    logic                   fresh_rd;
    logic                   seeded_rd;

    logic [KEEP_W:0]        keep_inv;
    logic [AVG_W+KEEP_W-1:0] prod_old;
    logic [AVG_W+KEEP_W:0]  prod_new;
    logic [AVG_W+KEEP_W+1:0] acc;
    logic [AVG_W-1:0]       avg_upd;
    logic [AVG_W:0]         rd_sum;
    logic [AVG_W-FRAC_W:0]  rd_round;
    logic [SAMPLE_W-1:0]    rd_value;

    // The update pass runs whenever an item is held and the result register is free or emptying.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - $bits(out_item_t)){1'b0}}, out_reg};

    assign is_conv = (in_reg.cmd == CMD_CONVERT);
    assign rd_ok   = (in_reg.read_slot < SLOT_W'(CHANNEL_COUNT));
    assign addr    = is_conv ? slot_reg : in_reg.read_slot;

    always_comb
    begin
        raw_rd    = '0;
        avg_rd    = '0;
        fresh_rd  = 1'b0;
        seeded_rd = 1'b0;
        if (is_conv || rd_ok)
        begin
            raw_rd    = raw_reg[addr];
            avg_rd    = avg_reg[addr];
            fresh_rd  = fresh_reg[addr];
            seeded_rd = seeded_reg[addr];
        end
    end

    // Exponential average: old * keep + new * (256 - keep), rounded half up.
    assign keep_inv = (KEEP_W+1)'(1 << KEEP_W) - {1'b0, keep_reg};
    assign prod_old = avg_rd * keep_reg;
    assign prod_new = {in_reg.sample, {FRAC_W{1'b0}}} * keep_inv;
    assign acc      = (AVG_W+KEEP_W+2)'(prod_old) + (AVG_W+KEEP_W+2)'(prod_new)
                    + (AVG_W+KEEP_W+2)'(1 << (FRAC_W - 1));
    assign avg_upd  = acc[AVG_W+FRAC_W-1:FRAC_W];

    assign rd_sum   = {1'b0, avg_rd} + (AVG_W+1)'(1 << (FRAC_W - 1));
    assign rd_round = rd_sum[AVG_W:FRAC_W];

    always_comb
    begin
        if (!filt_en_reg)
        begin
            rd_value = raw_rd;
        end
        else if (rd_round > (AVG_W-FRAC_W+1)'({SAMPLE_W{1'b1}}))
        begin
            rd_value = {SAMPLE_W{1'b1}};
        end
        else
        begin
            rd_value = rd_round[SAMPLE_W-1:0];
        end
    end

    always_comb
    begin
        if (is_conv && (slot_reg == SLOT_W'(CHANNEL_COUNT - 1)))
        begin
            slot_next = '0;
        end
        else if (is_conv)
        begin
            slot_next = slot_reg + SLOT_W'(1);
        end
        else
        begin
            slot_next = slot_reg;
        end
    end

    always_comb
    begin
        out_next           = '0;
        out_next.scan_slot = slot_next;
        out_next.next_mux  = map_reg[slot_next * MUX_W +: MUX_W];
        if (!is_conv && rd_ok)
        begin
            out_next.read_value  = rd_value;
            out_next.read_value8 = rd_value[SAMPLE_W-1:SAMPLE_W-VALUE8_W];
            out_next.was_fresh   = fresh_rd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg     <= MAP_RESET;
            filt_en_reg <= 1'b0;
            keep_reg    <= KEEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHANNEL_MAP:   map_reg     <= cfg_data;
                CFG_FILTER_ENABLE: filt_en_reg <= cfg_data[0];
                CFG_FILTER_KEEP:   keep_reg    <= cfg_data[KEEP_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_reg.cmd       <= cmd_t'(s_tuser);
            in_reg.sample    <= s_tdata[SAMPLE_W-1:0];
            in_reg.read_slot <= s_tdata[SAMPLE_W +: SLOT_W];
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg   <= '0;
            fresh_reg  <= '0;
            seeded_reg <= '0;
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                raw_reg[i] <= '0;
                avg_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            slot_reg <= slot_next;
            if (is_conv)
            begin
                raw_reg[addr]   <= in_reg.sample;
                fresh_reg[addr] <= 1'b1;
                if (filt_en_reg)
                begin
                    seeded_reg[addr] <= 1'b1;
                    avg_reg[addr]    <= seeded_rd ? avg_upd
                                                  : {in_reg.sample, {FRAC_W{1'b0}}};
                end
            end
            else if (rd_ok)
            begin
                fresh_reg[addr] <= 1'b0;
            end
        end
    end

    `ASSERT_ALWAYS(a_slot_in_range, slot_reg < SLOT_W'(CHANNEL_COUNT))
    `ASSERT_NEXT(a_pass_fills_result, advance, out_valid_reg)
    `ASSERT_NEXT(a_read_clears_fresh, advance && !is_conv && rd_ok, !fresh_reg[$past(addr)])
    `ASSERT_NEXT(a_conv_sets_fresh, advance && is_conv, fresh_reg[$past(addr)])

endmodule
